### hdl/uvs_pkg.sv
// Package for the UV sphere grid-point generator.
// Shared types, codes, constants and helper functions; no dependencies.
package uvs_pkg;

    localparam int MaxSlices   = 256;
    localparam int CordicSteps = 16;
    localparam logic signed [32:0] CordicGain = 33'sd652032874;

    localparam logic [31:0] ATAN_TAB [CordicSteps] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef enum logic [1:0] {
        KIND_POS = 2'd0,
        KIND_NRM = 2'd1,
        KIND_IDX = 2'd2,
        KIND_REJ = 2'd3
    } t_kind;

    localparam logic [2:0] CFG_SLICES = 3'd0;
    localparam logic [2:0] CFG_RADIUS = 3'd1;
    localparam logic [2:0] CFG_CCW    = 3'd2;
    localparam logic [2:0] CFG_STEP   = 3'd3;
    localparam logic [2:0] CFG_VSTEP  = 3'd4;

    // per-item data that rides along the trig pipeline
    typedef struct packed {
        logic        rej;
        logic        quad;
        logic        ccw;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [15:0] idx_a;
        logic [9:0]  s1;
    } t_side;

    // clamp to [-65536, 65535] and keep 17 bits
    function automatic logic [16:0] sat17(input logic signed [49:0] v);
        logic [16:0] r;
        if (v < -50'sd65536)     r = 17'h10000;
        else if (v > 50'sd65535) r = 17'h0ffff;
        else                     r = v[16:0];
        return r;
    endfunction

endpackage

### hdl/uvs_if.sv
// Handshake channels of the UV sphere generator: request in, result out.
// Depends on nothing.
interface uvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ring;
    logic [8:0] segment;
    modport source (output valid, ring, segment, input ready);
    modport sink   (input valid, ring, segment, output ready);
endinterface

interface uvs_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               last;
    logic signed [16:0] comp_x;
    logic signed [16:0] comp_y;
    logic signed [16:0] comp_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        corner_index;
    modport source (output valid, kind, last, comp_x, comp_y, comp_z, tex_u, tex_v,
                    corner_index, input ready);
    modport sink   (input valid, kind, last, comp_x, comp_y, comp_z, tex_u, tex_v,
                    corner_index, output ready);
endinterface

### hdl/uvs_cordic.sv
// Two-lane pipelined CORDIC: one rotation per stage, then quadrant fold.
// Uses uvs_pkg (arctangent table, gain, sideband type).
module uvs_cordic
    import uvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [15:0]        i_ph_a,
    input  logic [15:0]        i_ph_b,
    input  t_side              i_side,
    output logic               o_valid,
    output logic signed [17:0] o_sin_a,
    output logic signed [17:0] o_cos_a,
    output logic signed [17:0] o_sin_b,
    output logic signed [17:0] o_cos_b,
    output t_side              o_side
);

    logic                  r_v    [CordicSteps+1];
    logic signed [32:0]    r_xa   [CordicSteps+1];
    logic signed [32:0]    r_ya   [CordicSteps+1];
    logic signed [32:0]    r_za   [CordicSteps+1];
    logic signed [32:0]    r_xb   [CordicSteps+1];
    logic signed [32:0]    r_yb   [CordicSteps+1];
    logic signed [32:0]    r_zb   [CordicSteps+1];
    logic [1:0]            r_qa   [CordicSteps+1];
    logic [1:0]            r_qb   [CordicSteps+1];
    t_side                 r_sd   [CordicSteps+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_xa[0] <= CordicGain;
            r_ya[0] <= '0;
            r_za[0] <= 33'({i_ph_a[13:0], 16'h0000});
            r_qa[0] <= i_ph_a[15:14];
            r_xb[0] <= CordicGain;
            r_yb[0] <= '0;
            r_zb[0] <= 33'({i_ph_b[13:0], 16'h0000});
            r_qb[0] <= i_ph_b[15:14];
            r_sd[0] <= i_side;
        end
    end

    for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
        localparam logic signed [32:0] At = 33'(ATAN_TAB[k]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                if (r_za[k] >= 0) begin
                    r_xa[k+1] <= r_xa[k] - (r_ya[k] >>> k);
                    r_ya[k+1] <= r_ya[k] + (r_xa[k] >>> k);
                    r_za[k+1] <= r_za[k] - At;
                end else begin
                    r_xa[k+1] <= r_xa[k] + (r_ya[k] >>> k);
                    r_ya[k+1] <= r_ya[k] - (r_xa[k] >>> k);
                    r_za[k+1] <= r_za[k] + At;
                end
                if (r_zb[k] >= 0) begin
                    r_xb[k+1] <= r_xb[k] - (r_yb[k] >>> k);
                    r_yb[k+1] <= r_yb[k] + (r_xb[k] >>> k);
                    r_zb[k+1] <= r_zb[k] - At;
                end else begin
                    r_xb[k+1] <= r_xb[k] + (r_yb[k] >>> k);
                    r_yb[k+1] <= r_yb[k] - (r_xb[k] >>> k);
                    r_zb[k+1] <= r_zb[k] + At;
                end
                r_qa[k+1] <= r_qa[k];
                r_qb[k+1] <= r_qb[k];
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    // round to Q1.15, clamp to [-32768, 32768]
    function automatic logic signed [17:0] rnd15(input logic signed [32:0] v);
        logic signed [32:0] t;
        logic signed [17:0] r;
        t = (v + 33'sd16384) >>> 15;
        if (t < -33'sd32768)     r = -18'sd32768;
        else if (t > 33'sd32768) r = 18'sd32768;
        else                     r = t[17:0];
        return r;
    endfunction

    logic signed [17:0] sa, ca, sb, cb;
    logic signed [17:0] n_sin_a, n_cos_a, n_sin_b, n_cos_b;

    always_comb begin
        sa = rnd15(r_ya[CordicSteps]);
        ca = rnd15(r_xa[CordicSteps]);
        sb = rnd15(r_yb[CordicSteps]);
        cb = rnd15(r_xb[CordicSteps]);
        case (r_qa[CordicSteps])
            2'd0:    begin n_sin_a = sa;  n_cos_a = ca;  end
            2'd1:    begin n_sin_a = ca;  n_cos_a = -sa; end
            2'd2:    begin n_sin_a = -sa; n_cos_a = -ca; end
            default: begin n_sin_a = -ca; n_cos_a = sa;  end
        endcase
        case (r_qb[CordicSteps])
            2'd0:    begin n_sin_b = sb;  n_cos_b = cb;  end
            2'd1:    begin n_sin_b = cb;  n_cos_b = -sb; end
            2'd2:    begin n_sin_b = -sb; n_cos_b = -cb; end
            default: begin n_sin_b = -cb; n_cos_b = sb;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[CordicSteps];
        end
        if (i_en) begin
            o_sin_a <= n_sin_a;
            o_cos_a <= n_cos_a;
            o_sin_b <= n_sin_b;
            o_cos_b <= n_cos_b;
            o_side  <= r_sd[CordicSteps];
        end
    end

endmodule

### hdl/uv_sphere_vertex_index_gen_top.sv
// Top level of the UV sphere grid-point generator.
// Uses uvs_pkg, uvs_in_if / uvs_out_if and the uvs_cordic pipeline.
//
// One request (ring, segment) yields: a position result, a normal result with
// texture u/v, and for a point that opens a quad six corner indices (ccw:
// a,b,c,a,c,d; cw: c,b,a,d,c,a). An out-of-grid point yields one rejected
// result. The datapath is a 22-stage pipeline (index setup, CORDIC load, 16
// rotations for both angles side by side, quadrant fold, three multiply and
// rounding stages) feeding a result sequencer that emits one result a cycle
// while o_res.ready is high. It emits eight results for a quad point, two
// for an edge point and one for a rejected point, loading a new point only
// with the last result. The pipeline advances as one and freezes while M3
// holds a point the busy sequencer cannot take: nothing is dropped or repeated.
// Config registers may only be written while the block is idle.
module uv_sphere_vertex_index_gen_top
    import uvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    uvs_in_if.sink      i_req,
    uvs_out_if.source   o_res
);

    // ---------------- configuration registers
    logic [8:0]  r_slices;
    logic [15:0] r_radius;
    logic        r_ccw;
    logic [14:0] r_step;
    logic [16:0] r_vstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slices <= 9'd32;
            r_radius <= 16'd256;
            r_ccw    <= 1'b1;
            r_step   <= 15'd2048;
            r_vstep  <= 17'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLICES: r_slices <= i_cfg_data[8:0];
                CFG_RADIUS: r_radius <= i_cfg_data[15:0];
                CFG_CCW:    r_ccw    <= i_cfg_data[0];
                CFG_STEP:   r_step   <= i_cfg_data[14:0];
                CFG_VSTEP:  r_vstep  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- global advance
    logic en;        // whole pipeline moves when high
    logic ser_take;  // sequencer can load a new point this cycle
    logic r_m3_valid;

    assign en          = !(r_m3_valid && !ser_take);
    assign i_req.ready = en;

    // ---------------- stage 0: grid check, phases, texcoords, corner base
    logic [8:0]  s_c;
    logic [7:0]  p_c;
    logic [22:0] prod_i;
    logic [23:0] prod_j;
    logic [24:0] prod_v;
    logic [17:0] prod_a;
    t_side       n_side;

    always_comb begin
        if (r_slices < 9'd3)                   s_c = 9'd3;
        else if (r_slices > 9'(MaxSlices))     s_c = 9'(MaxSlices);
        else                                   s_c = r_slices;
        p_c    = s_c[8:1];
        prod_i = 23'(i_req.ring) * 23'(r_step);
        prod_j = 24'(i_req.segment) * 24'(r_step);
        prod_v = 25'(i_req.ring) * 25'(r_vstep);
        prod_a = 18'(i_req.ring) * 18'({1'b0, s_c} + 10'd1);
        n_side.rej   = (i_req.ring > p_c) || (i_req.segment > s_c);
        n_side.quad  = (i_req.ring < p_c) && (i_req.segment < s_c);
        n_side.ccw   = r_ccw;
        n_side.tex_u = (prod_j > 24'd65536) ? 17'h10000 : prod_j[16:0];
        n_side.tex_v = (prod_v >= 25'd65536) ? 17'd0 : 17'h10000 - prod_v[16:0];
        n_side.idx_a = prod_a[15:0] + 16'(i_req.segment);
        n_side.s1    = {1'b0, s_c} + 10'd1;
    end

    logic        r_s0_valid;
    logic [15:0] r_ph_i, r_ph_j;
    t_side       r_s0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_req.valid;
        end
        if (en) begin
            r_ph_i    <= prod_i[15:0];
            r_ph_j    <= prod_j[15:0];
            r_s0_side <= n_side;
        end
    end

    // ---------------- trig pipeline
    logic               c_valid;
    logic signed [17:0] st, ct, sp, cp;
    t_side              c_side;

    uvs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_ph_a  (r_ph_i),
        .i_ph_b  (r_ph_j),
        .i_side  (r_s0_side),
        .o_valid (c_valid),
        .o_sin_a (st),
        .o_cos_a (ct),
        .o_sin_b (sp),
        .o_cos_b (cp),
        .o_side  (c_side)
    );

    // ---------------- M1: trig products, remaining corners
    logic                r_m1_valid;
    logic signed [31:0]  r_ssp, r_scp;
    logic signed [34:0]  r_rct;
    logic signed [17:0]  r_m1_ct;
    logic [15:0]         r_m1_b, r_m1_c, r_m1_d;
    t_side               r_m1_side;
    logic signed [35:0]  m_ssp, m_scp;
    logic [15:0]         b_idx;

    assign m_ssp = st * sp;
    assign m_scp = st * cp;
    assign b_idx = c_side.idx_a + 16'(c_side.s1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= c_valid;
        end
        if (en) begin
            r_ssp     <= m_ssp[31:0];
            r_scp     <= m_scp[31:0];
            r_rct     <= 35'($signed({1'b0, r_radius})) * 35'(ct);
            r_m1_ct   <= ct;
            r_m1_b    <= b_idx;
            r_m1_c    <= b_idx + 16'd1;
            r_m1_d    <= c_side.idx_a + 16'd1;
            r_m1_side <= c_side;
        end
    end

    // ---------------- M2: radius products, normals, position y
    logic                r_m2_valid;
    logic signed [48:0]  r_rssp, r_rscp;
    logic [16:0]         r_nx, r_ny, r_nz, r_py;
    logic [15:0]         r_m2_b, r_m2_c, r_m2_d;
    t_side               r_m2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_m2_valid <= r_m1_valid;
        end
        if (en) begin
            r_rssp    <= 49'($signed({1'b0, r_radius})) * 49'(r_ssp);
            r_rscp    <= 49'($signed({1'b0, r_radius})) * 49'(r_scp);
            r_nx      <= sat17((50'(r_ssp) + 50'sd16384) >>> 15);
            r_nz      <= sat17((50'(r_scp) + 50'sd16384) >>> 15);
            r_ny      <= r_m1_ct[16:0];
            r_py      <= sat17((50'(r_rct) + 50'sd16384) >>> 15);
            r_m2_b    <= r_m1_b;
            r_m2_c    <= r_m1_c;
            r_m2_d    <= r_m1_d;
            r_m2_side <= r_m1_side;
        end
    end

    // ---------------- M3: position x and z
    logic [16:0] r_px, r_pz, r_m3_nx, r_m3_ny, r_m3_nz, r_m3_py;
    logic [15:0] r_m3_b, r_m3_c, r_m3_d;
    t_side       r_m3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (en) begin
            r_m3_valid <= r_m2_valid;
        end
        if (en) begin
            r_px      <= sat17((50'(r_rssp) + 50'sd536870912) >>> 30);
            r_pz      <= sat17((50'(r_rscp) + 50'sd536870912) >>> 30);
            r_m3_nx   <= r_nx;
            r_m3_ny   <= r_ny;
            r_m3_nz   <= r_nz;
            r_m3_py   <= r_py;
            r_m3_b    <= r_m2_b;
            r_m3_c    <= r_m2_c;
            r_m3_d    <= r_m2_d;
            r_m3_side <= r_m2_side;
        end
    end

    // ---------------- result sequencer (doubles as output register)
    logic        r_svalid;
    logic [2:0]  r_cnt;
    logic [16:0] r_px_q, r_py_q, r_pz_q, r_nx_q, r_ny_q, r_nz_q;
    logic [15:0] r_a_q, r_b_q, r_c_q, r_d_q;
    t_side       r_sd_q;
    logic        last_now;

    assign last_now = r_sd_q.rej || (!r_sd_q.quad && r_cnt == 3'd1) || (r_cnt == 3'd7);
    assign ser_take = !r_svalid || (o_res.ready && last_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svalid <= 1'b0;
            r_cnt    <= '0;
        end else if (ser_take) begin
            r_svalid <= r_m3_valid;
            r_cnt    <= '0;
        end else if (o_res.ready) begin
            r_cnt    <= r_cnt + 3'd1;
        end
        if (ser_take) begin
            r_px_q <= r_px;
            r_py_q <= r_m3_py;
            r_pz_q <= r_pz;
            r_nx_q <= r_m3_nx;
            r_ny_q <= r_m3_ny;
            r_nz_q <= r_m3_nz;
            r_a_q  <= r_m3_side.idx_a;
            r_b_q  <= r_m3_b;
            r_c_q  <= r_m3_c;
            r_d_q  <= r_m3_d;
            r_sd_q <= r_m3_side;
        end
    end

    // corner order: ccw a,b,c,a,c,d ; cw c,b,a,d,c,a
    logic [15:0] corner;
    always_comb begin
        case (r_cnt)
            3'd2:    corner = r_sd_q.ccw ? r_a_q : r_c_q;
            3'd3:    corner = r_b_q;
            3'd4:    corner = r_sd_q.ccw ? r_c_q : r_a_q;
            3'd5:    corner = r_sd_q.ccw ? r_a_q : r_d_q;
            3'd6:    corner = r_c_q;
            3'd7:    corner = r_sd_q.ccw ? r_d_q : r_a_q;
            default: corner = '0;
        endcase
    end

    always_comb begin
        o_res.valid        = r_svalid;
        o_res.last         = last_now;
        o_res.comp_x       = '0;
        o_res.comp_y       = '0;
        o_res.comp_z       = '0;
        o_res.tex_u        = '0;
        o_res.tex_v        = '0;
        o_res.corner_index = '0;
        if (r_sd_q.rej) begin
            o_res.kind = KIND_REJ;
        end else if (r_cnt == 3'd0) begin
            o_res.kind   = KIND_POS;
            o_res.comp_x = r_px_q;
            o_res.comp_y = r_py_q;
            o_res.comp_z = r_pz_q;
        end else if (r_cnt == 3'd1) begin
            o_res.kind   = KIND_NRM;
            o_res.comp_x = r_nx_q;
            o_res.comp_y = r_ny_q;
            o_res.comp_z = r_nz_q;
            o_res.tex_u  = r_sd_q.tex_u;
            o_res.tex_v  = r_sd_q.tex_v;
        end else begin
            o_res.kind         = KIND_IDX;
            o_res.corner_index = corner;
        end
    end

    // ---------------- assertions
    a_rej_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_sd_q.rej) |-> (o_res.last && r_cnt == 3'd0))
        else $error("rejected point must be a single result");

    a_edge_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !r_sd_q.quad) |-> (r_cnt == 3'd0 || r_cnt == 3'd1))
        else $error("edge point ran past its normal result");

    a_hold_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m3_valid && !en) |=> (r_m3_valid && $stable(r_px) && $stable(r_m3_side)))
        else $error("stalled pipeline tail changed");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !last_now) |=> (o_res.valid && r_cnt == $past(r_cnt) + 3'd1))
        else $error("sequencer skipped or lost a result");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

### tb/uvs_sphere_sb.sv
// Scoreboard for the UV sphere generator: predicts results of accepted requests
// and checks observed results. Depends on uvs_pkg.
package uvs_sphere_sb_pkg;
    import uvs_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic               last;
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic signed [16:0] cz;
        logic [16:0]        tu;
        logic [16:0]        tv;
        logic [15:0]        corner;
    } t_vtx_res;

    class sphere_scoreboard;
        int unsigned slices = 32;
        int unsigned radius = 256;
        bit          ccw = 1;
        int unsigned step = 2048;
        int unsigned vstep = 4096;
        t_vtx_res    pending[$];
        int          errors;
        int          checked;

        function automatic longint floor_shr(longint v, int k);
            return v >>> k;
        endfunction

        function automatic longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function automatic void sin_cos(longint ph, output longint s, output longint c);
            longint w, x, y, z, dx, dy, sr, cr;
            int q;
            w = (ph & 64'hffff) << 16;
            q = int'(w >> 30);
            z = w & 64'h3fffffff;
            x = 652032874;
            y = 0;
            for (int k = 0; k < CordicSteps; k++) begin
                dx = floor_shr(y, k);
                dy = floor_shr(x, k);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[k]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[k]);
                end
            end
            sr = clip(floor_shr(y + 16384, 15), -32768, 32768);
            cr = clip(floor_shr(x + 16384, 15), -32768, 32768);
            case (q)
                0: begin s = sr; c = cr; end
                1: begin s = cr; c = -sr; end
                2: begin s = -sr; c = -cr; end
                default: begin s = -cr; c = sr; end
            endcase
        endfunction

        function void write_reg(logic [2:0] idx, logic [16:0] d);
            case (idx)
                CFG_SLICES: slices = 32'(d[8:0]);
                CFG_RADIUS: radius = 32'(d[15:0]);
                CFG_CCW:    ccw = d[0];
                CFG_STEP:   step = 32'(d[14:0]);
                CFG_VSTEP:  vstep = 32'(d[16:0]);
                default: ;
            endcase
        endfunction

        function void note_request(int unsigned ring, int unsigned seg);
            int unsigned s, p, a, b, c, d;
            longint st, ct, sp, cp, u, tv;
            t_vtx_res r;
            int unsigned seq[6];
            s = slices < 3 ? 3 : (slices > MaxSlices ? MaxSlices : slices);
            p = s / 2;
            if (ring > p || seg > s) begin
                r = '0; r.kind = KIND_REJ; r.last = 1'b1;
                pending.push_back(r);
                return;
            end
            sin_cos(longint'(ring) * step, st, ct);
            sin_cos(longint'(seg) * step, sp, cp);
            r = '0;
            r.kind = KIND_POS;
            r.cx = 17'(clip(floor_shr(radius * st * sp + (64'sd1 <<< 29), 30), -65536, 65535));
            r.cy = 17'(clip(floor_shr(radius * ct + 16384, 15), -65536, 65535));
            r.cz = 17'(clip(floor_shr(radius * st * cp + (64'sd1 <<< 29), 30), -65536, 65535));
            pending.push_back(r);
            u = longint'(seg) * step;
            if (u > 65536) u = 65536;
            tv = longint'(ring) * vstep;
            r = '0;
            r.kind = KIND_NRM;
            r.cx = 17'(clip(floor_shr(st * sp + 16384, 15), -65536, 65535));
            r.cy = 17'(ct);
            r.cz = 17'(clip(floor_shr(st * cp + 16384, 15), -65536, 65535));
            r.tu = 17'(u);
            r.tv = 17'(tv >= 65536 ? 0 : 65536 - tv);
            if (!(ring < p && seg < s)) begin
                r.last = 1'b1;
                pending.push_back(r);
                return;
            end
            pending.push_back(r);
            a = ring * (s + 1) + seg;
            b = (ring + 1) * (s + 1) + seg;
            c = b + 1;
            d = a + 1;
            if (ccw) seq = '{a, b, c, a, c, d};
            else     seq = '{c, b, a, d, c, a};
            for (int k = 0; k < 6; k++) begin
                r = '0;
                r.kind = KIND_IDX;
                r.corner = 16'(seq[k]);
                r.last = (k == 5);
                pending.push_back(r);
            end
        endfunction

        function void check_result(t_vtx_res got);
            t_vtx_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.kind !== e.kind) report("kind", 17'(e.kind), 17'(got.kind));
            if (got.last !== e.last) report("last", 17'(e.last), 17'(got.last));
            if (got.cx !== e.cx) report("comp_x", e.cx, got.cx);
            if (got.cy !== e.cy) report("comp_y", e.cy, got.cy);
            if (got.cz !== e.cz) report("comp_z", e.cz, got.cz);
            if (got.tu !== e.tu) report("tex_u", e.tu, got.tu);
            if (got.tv !== e.tv) report("tex_v", e.tv, got.tv);
            if (got.corner !== e.corner)
                report("corner_index", 17'(e.corner), 17'(got.corner));
        endfunction

        function void report(string f, logic [16:0] e, logic [16:0] g);
            $display("%0t: %s mismatch expected %h actual %h", $time, f, e, g);
            errors++;
        endfunction
    endclass
endpackage

### tb/uv_sphere_vertex_index_gen_top_test.sv
// Top-level test of the UV sphere grid-point generator.
// Depends on uvs_pkg, uvs_if, uvs_sphere_sb and the top-level RTL.
module uv_sphere_vertex_index_gen_top_test
    import uvs_pkg::*, uvs_sphere_sb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;

    uvs_in_if  req_ch();
    uvs_out_if res_ch();

    sphere_scoreboard sb = new();
    int unsigned n_req;
    bit          hold_off;   // forces a long receiver stall
    bit          sink_on;

    uv_sphere_vertex_index_gen_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.ring = '0;
        req_ch.segment = '0;
        res_ch.ready = 1'b0;
    end

    // mostly short gaps, occasionally a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // check accepted results; receiver below: random stalls, long one on hold_off
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            sb.check_result('{res_ch.kind, res_ch.last, res_ch.comp_x, res_ch.comp_y,
                              res_ch.comp_z, res_ch.tex_u, res_ch.tex_v,
                              res_ch.corner_index});
        end
    end

    initial begin
        int g;
        @(posedge i_clk);
        while (1) begin
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else if (!sink_on) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                g = gap_len();
                if (g > 0 && $urandom_range(0, 2) == 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // one request; valid stays high when the next follows with no gap
    task automatic send_req(int unsigned ring, int unsigned seg, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.ring <= 8'(ring);
        req_ch.segment <= 9'(seg);
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(ring, seg);
        n_req++;
    endtask

    // wait for the queue to drain plus pipeline latency
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [16:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        i_cfg_we <= 1'b0;
    endtask

    // draw a request: mostly in-grid, some edges, some out of grid / raw noise
    task automatic rand_req(bit gaps);
        int unsigned s, p, r;
        s = sb.slices < 3 ? 3 : (sb.slices > MaxSlices ? MaxSlices : sb.slices);
        p = s / 2;
        r = $urandom_range(0, 99);
        if (r < 70) send_req($urandom_range(0, p - 1), $urandom_range(0, s - 1), gaps);
        else if (r < 80) send_req(p, $urandom_range(0, s), gaps);
        else if (r < 88) send_req($urandom_range(0, p), s, gaps);
        else send_req($urandom_range(0, 255), $urandom_range(0, 511), gaps);
    endtask

    task automatic set_all(int unsigned s, int unsigned rad, bit c, int unsigned st,
                           int unsigned vs);
        write_cfg(CFG_SLICES, 17'(s));
        write_cfg(CFG_RADIUS, 17'(rad));
        write_cfg(CFG_CCW, 17'(c));
        write_cfg(CFG_STEP, 17'(st));
        write_cfg(CFG_VSTEP, 17'(vs));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, corners, edges, out-of-grid, field extremes
        send_req(0, 0, 0);
        send_req(15, 31, 0);
        send_req(16, 0, 0);
        send_req(0, 32, 0);
        send_req(16, 32, 0);
        send_req(17, 0, 0);
        send_req(0, 33, 0);
        send_req(255, 511, 0);
        send_req(8, 8, 0);
        drain();
        // clockwise, zero radius, tiny step, slices below range
        set_all(0, 0, 0, 1, 512);
        send_req(0, 0, 0);
        send_req(1, 2, 0);
        send_req(1, 3, 0);
        send_req(2, 0, 0);
        drain();
        // max slices and radius, large step (phase wraps, tex saturates/floors)
        set_all(511, 65535, 1, 21845, 65536);
        send_req(127, 255, 0);
        send_req(128, 256, 0);
        send_req(1, 100, 0);
        send_req(129, 0, 0);
        send_req(0, 257, 0);
        drain();
        set_all(256, 65535, 0, 32767, 131071);
        send_req(100, 200, 0);
        send_req(128, 3, 0);
        drain();

        // random phases: a new setting per phase, mostly small grids
        sink_on = 1;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) set_all($urandom_range(200, 256), $urandom_range(1, 65535),
                                 1'($urandom_range(0, 1)), $urandom_range(1, 21845),
                                 $urandom_range(512, 65536));
            else set_all($urandom_range(3, 40), $urandom_range(0, 65535),
                         1'($urandom_range(0, 1)), $urandom_range(0, 32767),
                         $urandom_range(0, 131071));
            if (ph == 2) hold_off = 1;   // receiver stalls while requests keep coming
            for (int k = 0; k < 50; k++) rand_req(ph != 2);
            drain();
        end

        $display("covered %0d requests, %0d results over several slice/radius/winding",
                 n_req, sb.checked);
        $display("settings including extremes, with stalls on both sides");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("uv_sphere_vertex_index_gen_top regression: pass");
        else
            $display("uv_sphere_vertex_index_gen_top regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("uv_sphere_vertex_index_gen_top regression: fail");
        $finish;
    end
endmodule

### uv_sphere_vertex_index_gen_top.f
hdl/uvs_pkg.sv
hdl/uvs_if.sv
hdl/uvs_cordic.sv
hdl/uv_sphere_vertex_index_gen_top.sv
tb/uvs_sphere_sb.sv
tb/uv_sphere_vertex_index_gen_top_test.sv
